// ===== hdl/ple_pkg.sv =====
// shared constants, codes and types for the positional list engine
package ple_pkg;

  // list capacity and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int FUNC_W   = 3;
  localparam int POS_W    = 8;
  localparam int CMP_W    = 9;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 5;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_INS_HEAD = 3'd0,
    FN_INS_TAIL = 3'd1,
    FN_INS_POS  = 3'd2,
    FN_DEL_HEAD = 3'd3,
    FN_DEL_TAIL = 3'd4,
    FN_DEL_POS  = 3'd5,
    FN_DUMP     = 3'd6
  } func_e;

  // status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    CM_HOLD = 2'd0,
    CM_INS  = 2'd1,
    CM_DEL  = 2'd2,
    CM_ROT  = 2'd3
  } cell_mode_e;

  // sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_e;

  // control broadcast to the cell row
  typedef struct packed {
    cell_mode_e           mode;
    logic [IDX_W-1:0]     idx;
    logic [IDX_W-1:0]     last_idx;
  } cell_ctrl_t;

endpackage

// ===== hdl/ple_cell.sv =====
// one list cell: holds a word and shifts, rotates or loads it
module ple_cell
  import ple_pkg::*;
(
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [IDX_W-1:0]  cell_idx_i,
  input  logic [WORD_W-1:0] word_i,
  input  logic [WORD_W-1:0] left_i,
  input  logic [WORD_W-1:0] right_i,
  input  logic [WORD_W-1:0] head_i,
  output logic [WORD_W-1:0] data_o
);

  logic [WORD_W-1:0] data_q;
  logic [WORD_W-1:0] data_d;

  // choose the next word from the neighbors
  always_comb begin
    data_d = data_q;
    case (ctrl_i.mode)
      CM_INS: begin
        if (cell_idx_i == ctrl_i.idx) begin
          data_d = word_i;
        end else if (cell_idx_i > ctrl_i.idx) begin
          data_d = left_i;
        end
      end
      CM_DEL: begin
        if (cell_idx_i >= ctrl_i.idx) begin
          data_d = right_i;
        end
      end
      CM_ROT: begin
        if (cell_idx_i == ctrl_i.last_idx) begin
          data_d = head_i;
        end else if (cell_idx_i < ctrl_i.last_idx) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // word storage
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== hdl/positional_list_engine.sv =====
// Ordered list of up to CAPACITY signed words held in a row of shifting cells. An operation is
// taken when start_i is high and busy_o is low. Insert, delete and unused codes each give one
// result (valid_o, last_o high) in the next cycle with the status and new count, and a new
// operation may be started every cycle. A dump sends its elements out one at a time, because
// elements leave from the head cell while the occupied cells rotate by one each cycle; busy_o
// is high while the dump runs and the results come one per cycle, the last one marked by
// last_o. An empty dump gives one result with status list empty.
// Results appear for exactly one cycle and cannot be held off by the receiver.
module positional_list_engine
  import ple_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic signed [WORD_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,
  output logic                     valid_o,
  output logic [STAT_W-1:0]        status_o,
  output logic [COUNT_W-1:0]       count_o,
  output logic signed [WORD_W-1:0] element_o,
  output logic                     has_element_o,
  output logic                     last_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  held_q, held_d;
  logic [CNT_W-1:0]  dcnt_q, dcnt_d;
  cell_ctrl_t        ctrl;

  logic              valid_q, valid_d;
  logic              last_q, last_d;
  logic              has_q, has_d;
  status_e           status_q, status_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [WORD_W-1:0] elem_q, elem_d;

  logic [WORD_W-1:0] cell_data [CAPACITY];

  logic              accept;
  logic [CMP_W-1:0]  pos_ext, held_ext;
  logic              is_full, is_empty;
  logic [CNT_W-1:0]  held_m1;

  assign accept   = start_i && (state_q == S_IDLE);
  assign pos_ext  = CMP_W'(position_i);
  assign held_ext = CMP_W'(held_q);
  assign is_full  = (held_q >= CNT_W'(CAPACITY));
  assign is_empty = (held_q == '0);
  assign held_m1  = held_q - CNT_W'(1);

  // sequencer: decode the request, drive the cell row and build the result
  always_comb begin
    state_d       = state_q;
    held_d        = held_q;
    dcnt_d        = dcnt_q;
    ctrl.mode     = CM_HOLD;
    ctrl.idx      = '0;
    ctrl.last_idx = held_m1[IDX_W-1:0];
    valid_d       = 1'b0;
    last_d        = 1'b0;
    has_d         = 1'b0;
    status_d      = ST_DONE;
    elem_d        = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          valid_d = 1'b1;
          last_d  = 1'b1;
          case (func_i)
            FN_INS_HEAD, FN_INS_TAIL: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else begin
                ctrl.mode = CM_INS;
                ctrl.idx  = (func_i == FN_INS_HEAD) ? '0 : held_q[IDX_W-1:0];
                held_d    = held_q + CNT_W'(1);
              end
            end
            FN_INS_POS: begin
              if (pos_ext == '0 || pos_ext > held_ext + CMP_W'(1)) begin
                status_d = ST_RANGE;
              end else if (is_full) begin
                status_d = ST_FULL;
              end else begin
                ctrl.mode = CM_INS;
                ctrl.idx  = IDX_W'(position_i - POS_W'(1));
                held_d    = held_q + CNT_W'(1);
              end
            end
            FN_DEL_HEAD, FN_DEL_TAIL: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else begin
                ctrl.mode = CM_DEL;
                ctrl.idx  = (func_i == FN_DEL_HEAD) ? '0 : held_m1[IDX_W-1:0];
                held_d    = held_m1;
              end
            end
            FN_DEL_POS: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else if (pos_ext == '0 || pos_ext > held_ext) begin
                status_d = ST_RANGE;
              end else begin
                ctrl.mode = CM_DEL;
                ctrl.idx  = IDX_W'(position_i - POS_W'(1));
                held_d    = held_m1;
              end
            end
            FN_DUMP: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else begin
                valid_d = 1'b0;
                last_d  = 1'b0;
                dcnt_d  = '0;
                state_d = S_DUMP;
              end
            end
            default: status_d = ST_DONE;
          endcase
        end
      end
      S_DUMP: begin
        // head cell goes out, occupied cells rotate toward the head
        valid_d   = 1'b1;
        has_d     = 1'b1;
        elem_d    = cell_data[0];
        ctrl.mode = CM_ROT;
        dcnt_d    = dcnt_q + CNT_W'(1);
        if (dcnt_q == held_m1) begin
          last_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    count_d = COUNT_W'(held_d);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      held_q  <= '0;
      dcnt_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      dcnt_q  <= dcnt_d;
      valid_q <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    last_q   <= last_d;
    has_q    <= has_d;
    status_q <= status_d;
    count_q  <= count_d;
    elem_q   <= elem_d;
  end

  // row of cells, each wired to its neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = value_i;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    ple_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .cell_idx_i (IDX_W'(g)),
      .word_i     (value_i),
      .left_i     (left_w),
      .right_i    (right_w),
      .head_i     (cell_data[0]),
      .data_o     (cell_data[g])
    );
  end

  assign busy_o        = (state_q == S_DUMP);
  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign count_o       = count_q;
  assign element_o     = elem_q;
  assign has_element_o = has_q;
  assign last_o        = last_q;

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_dump_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> valid_o && has_element_o)
    else $error("dump cycle gave no element");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && func_i != FN_DUMP |=> valid_o && last_o && !has_element_o)
    else $error("missing single result");

  a_element_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && has_element_o |-> status_o == ST_DONE)
    else $error("element carried with non-done status");

  a_dump_count_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> $stable(held_q))
    else $error("count changed during dump");
`endif

endmodule
